### rtl/ffba_pkg.sv
// Package for the first-fit bitmap allocator.
// Holds the item kind codes, the row width and the controller/datapath structs.
// No dependencies.
`default_nettype none

package ffba_pkg;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam int ROW_BITS = 8;

    typedef struct packed {
        logic load;
        logic clr_start;
        logic clr_wr;
        logic scan_start;
        logic scan_en;
        logic mod_step;
        logic fill_load_alloc;
        logic fill_load_free;
        logic fill_wr;
        logic res_ok;
        logic res_hit;
        logic res_nak;
    } ffba_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       len_bad;
        logic       len_zero;
        logic       mod_done;
        logic       hit;
        logic       fail;
        logic       fill_last;
        logic       clr_last;
    } ffba_sts_t;

endpackage

`default_nettype wire

### rtl/ffba_dpath.sv
// Datapath of the first-fit bitmap allocator: occupancy memory, scan unit,
// fill unit, clear counter and result register. Depends on ffba_pkg.
`default_nettype none

module ffba_dpath #(
    parameter int SLOTS = 1024
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire  ffba_pkg::ffba_cmd_t cmd,
    output ffba_pkg::ffba_sts_t sts,
    input  wire  [1:0]         in_kind,
    input  wire  [9:0]         in_start_addr,
    input  wire  [10:0]        in_length,
    output logic               res_granted,
    output logic [9:0]         res_found_addr
);

    localparam int UW   = $clog2(SLOTS);
    localparam int RW   = UW - 3;
    localparam int ROWS = (SLOTS + 7) / 8;
    localparam int LW   = $clog2(SLOTS + 1);
    localparam int CW   = (LW > 11) ? LW : 11;
    localparam int AW   = (UW > 10) ? UW : 10;
    localparam logic [UW:0] SLOTS_U = (UW + 1)'(SLOTS);
    localparam logic [CW:0] SLOTS_C = (CW + 1)'(SLOTS);
    localparam logic [AW:0] SLOTS_A = (AW + 1)'(SLOTS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    logic [ffba_pkg::ROW_BITS-1:0] mem [ROWS];

    logic [1:0]     kind_reg;
    logic [AW-1:0]  addr_reg;
    logic [10:0]    len_reg;
    logic [RW-1:0]  clr_row_reg;
    logic [RW-1:0]  srow_reg;
    logic           spass_reg;
    logic           pvalid_reg;
    logic [RW-1:0]  prow_reg;
    logic           ppass_reg;
    logic [LW-1:0]  run_reg;
    logic [LW-1:0]  run_next;
    logic [UW-1:0]  cand_reg;
    logic [UW-1:0]  cand_next;
    logic [7:0]     rdata_reg;
    logic [UW-1:0]  fu_reg;
    logic [LW-1:0]  rem_reg;
    logic           fval_reg;
    logic           granted_reg;
    logic [UW-1:0]  res_addr_reg;

    logic [RW-1:0]  rd_row;
    logic           hit_c;
    logic           fail_c;
    logic [CW-1:0]  len_c;

    // fill unit signals
    logic [RW-1:0]  f_row;
    logic [2:0]     f_off;
    logic [UW:0]    f_base;
    logic [UW:0]    f_left;
    logic [UW:0]    f_base8;
    logic [3:0]     f_cap;
    logic [3:0]     f_avail;
    logic [3:0]     f_cnt;
    logic [7:0]     f_mask;
    logic [7:0]     f_wdata;
    logic [AW-1:0]  res_ext;

    assign len_c = CW'(len_reg);

    // Scan one row: up to eight units, each extending or breaking the free run.
    always_comb begin
        logic [UW-1:0] u;
        logic [LW-1:0] r;
        logic [UW-1:0] c;
        logic          h;
        logic          f;
        r = run_reg;
        c = cand_reg;
        h = 1'b0;
        f = 1'b0;
        for (int i = 0; i < 8; i++) begin
            u = {prow_reg, 3'(i)};
            if (!h && !f && ({1'b0, u} < SLOTS_U)) begin
                if (!rdata_reg[i]) begin
                    if (r == '0) begin
                        if (ppass_reg) f = 1'b1;
                        else           c = u;
                    end
                    if (!f) begin
                        r = r + LW'(1);
                        if (CW'(r) == len_c) h = 1'b1;
                    end
                end else begin
                    if (ppass_reg) f = 1'b1;
                    else           r = '0;
                end
            end
        end
        // end of the wrap pass without a fit
        if (!h && ppass_reg && (prow_reg == LAST_ROW)) f = 1'b1;
        run_next  = r;
        cand_next = c;
        hit_c     = pvalid_reg && h;
        fail_c    = pvalid_reg && f;
    end

    // Fill one row from fu_reg, at most rem_reg units, wrapping at the map end.
    always_comb begin
        f_row   = fu_reg[UW-1:3];
        f_off   = fu_reg[2:0];
        f_base  = {1'b0, f_row, 3'b000};
        f_left  = SLOTS_U - f_base;
        f_cap   = (f_left > (UW + 1)'(8)) ? 4'd8 : f_left[3:0];
        f_avail = f_cap - {1'b0, f_off};
        f_cnt   = (rem_reg < LW'(f_avail)) ? rem_reg[3:0] : f_avail;
        f_base8 = f_base + (UW + 1)'(8);
        for (int i = 0; i < 8; i++) begin
            f_mask[i] = (4'(i) >= {1'b0, f_off}) &&
                        (5'(i) < ({2'b00, f_off} + {1'b0, f_cnt}));
        end
        f_wdata = fval_reg ? (rdata_reg | f_mask) : (rdata_reg & ~f_mask);
    end

    assign rd_row = cmd.scan_en ? srow_reg : fu_reg[UW-1:3];

    // Occupancy memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            mem[clr_row_reg] <= '0;
        end else if (cmd.fill_wr) begin
            mem[f_row] <= f_wdata;
        end
        rdata_reg <= mem[rd_row];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_row_reg <= '0;
            pvalid_reg  <= 1'b0;
        end else begin
            if (cmd.clr_start) begin
                clr_row_reg <= '0;
            end else if (cmd.clr_wr) begin
                clr_row_reg <= (clr_row_reg == LAST_ROW) ? '0 : clr_row_reg + RW'(1);
            end
            if (cmd.scan_start) begin
                pvalid_reg <= 1'b0;
            end else if (cmd.scan_en) begin
                pvalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= in_kind;
            addr_reg <= AW'(in_start_addr);
            len_reg  <= in_length;
        end else if (cmd.mod_step) begin
            addr_reg <= AW'({1'b0, addr_reg} - SLOTS_A);
        end

        if (cmd.scan_start) begin
            srow_reg  <= '0;
            spass_reg <= 1'b0;
            run_reg   <= '0;
            cand_reg  <= '0;
        end else if (cmd.scan_en) begin
            srow_reg  <= (srow_reg == LAST_ROW) ? '0 : srow_reg + RW'(1);
            spass_reg <= spass_reg | (srow_reg == LAST_ROW);
            prow_reg  <= srow_reg;
            ppass_reg <= spass_reg;
            if (pvalid_reg) begin
                run_reg  <= run_next;
                cand_reg <= cand_next;
            end
        end

        if (cmd.fill_load_alloc) begin
            fu_reg   <= cand_next;
            rem_reg  <= LW'(len_reg);
            fval_reg <= 1'b1;
        end else if (cmd.fill_load_free) begin
            fu_reg   <= addr_reg[UW-1:0];
            rem_reg  <= ((CW + 1)'(len_reg) > SLOTS_C) ? LW'(SLOTS) : LW'(len_reg);
            fval_reg <= 1'b0;
        end else if (cmd.fill_wr) begin
            fu_reg   <= (f_base8 >= SLOTS_U) ? '0 : f_base8[UW-1:0];
            rem_reg  <= rem_reg - LW'(f_cnt);
        end

        if (cmd.res_hit) begin
            granted_reg  <= 1'b1;
            res_addr_reg <= cand_next;
        end else if (cmd.res_ok) begin
            granted_reg  <= 1'b1;
            res_addr_reg <= '0;
        end else if (cmd.res_nak) begin
            granted_reg  <= 1'b0;
            res_addr_reg <= '0;
        end
    end

    assign res_ext        = AW'(res_addr_reg);
    assign res_granted    = granted_reg;
    assign res_found_addr = res_ext[9:0];

    always_comb begin
        sts.kind      = kind_reg;
        sts.len_bad   = (len_reg == '0) || ((CW + 1)'(len_reg) > SLOTS_C);
        sts.len_zero  = (len_reg == '0);
        sts.mod_done  = ({1'b0, addr_reg} < SLOTS_A);
        sts.hit       = hit_c;
        sts.fail      = fail_c;
        sts.fill_last = ({1'b0, rem_reg} == (LW + 1)'(f_cnt));
        sts.clr_last  = (clr_row_reg == LAST_ROW);
    end

endmodule

`default_nettype wire

### rtl/ffba_ctrl.sv
// Controller of the first-fit bitmap allocator: sequences clear sweeps, scans
// and fills, and owns the result valid flag. Depends on ffba_pkg.
`default_nettype none

module ffba_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_fire,
    input  wire                 m_tready,
    output logic                s_ready,
    output logic                m_valid,
    output ffba_pkg::ffba_cmd_t cmd,
    input  wire ffba_pkg::ffba_sts_t sts
);

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_DEC, ST_CLR, ST_MOD, ST_SCAN, ST_FILL_RD, ST_FILL_WR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   respond;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        respond    = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                case (sts.kind)
                    ffba_pkg::KIND_ALLOC: begin
                        if (sts.len_bad) begin
                            cmd.res_nak = 1'b1;
                            respond     = 1'b1;
                            state_next  = ST_IDLE;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    ffba_pkg::KIND_FREE: begin
                        state_next = ST_MOD;
                    end
                    ffba_pkg::KIND_CLEAR: begin
                        cmd.clr_start = 1'b1;
                        state_next    = ST_CLR;
                    end
                    default: begin
                        cmd.res_nak = 1'b1;
                        respond     = 1'b1;
                        state_next  = ST_IDLE;
                    end
                endcase
            end
            ST_CLR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    cmd.res_ok = 1'b1;
                    respond    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MOD: begin
                if (!sts.mod_done) begin
                    cmd.mod_step = 1'b1;
                end else begin
                    cmd.fill_load_free = 1'b1;
                    cmd.res_ok         = 1'b1;
                    if (sts.len_zero) begin
                        respond    = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_FILL_RD;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (sts.hit) begin
                    cmd.res_hit         = 1'b1;
                    cmd.fill_load_alloc = 1'b1;
                    state_next          = ST_FILL_RD;
                end else if (sts.fail) begin
                    cmd.res_nak = 1'b1;
                    respond     = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_FILL_RD: begin
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                cmd.fill_wr = 1'b1;
                if (sts.fill_last) begin
                    respond    = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_FILL_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (respond) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/first_fit_bitmap_allocator.sv
// First-fit bitmap allocator over SLOTS units, 8 units per memory row.
// Allocate: decode, then a scan of up to 2*ceil(SLOTS/8) rows, then a read and a
// write per row marked. Free: decode, start reduction, a read and a write per row touched.
// Clear: decode, then a sweep of all ceil(SLOTS/8) rows, one row written per cycle. One item at a time.
// After aresetn the block sweeps the map clear and holds s_tready low meanwhile.
// Depends on ffba_pkg, ffba_ctrl, ffba_dpath.
`default_nettype none

module first_fit_bitmap_allocator #(
    parameter int SLOTS = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input transaction
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [9:0] start_addr, [20:10] length, rest zero
    input  wire  [1:0]  s_tuser,   // [1:0] kind
    // result transaction
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [9:0] found_addr, rest zero
    output logic        m_tuser    // [0] granted
);

    ffba_pkg::ffba_cmd_t cmd;
    ffba_pkg::ffba_sts_t sts;
    logic                s_fire;
    logic                granted;
    logic [9:0]          found_addr;

    // accept a transaction only when idle and the result slot is free or leaving
    assign s_fire = s_tvalid && s_tready;

    ffba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_fire   (s_fire),
        .m_tready (m_tready),
        .s_ready  (s_tready),
        .m_valid  (m_tvalid),
        .cmd      (cmd),
        .sts      (sts)
    );

    ffba_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_kind        (s_tuser),
        .in_start_addr  (s_tdata[9:0]),
        .in_length      (s_tdata[20:10]),
        .res_granted    (granted),
        .res_found_addr (found_addr)
    );

    // result payload is held in datapath registers until taken
    assign m_tdata = {6'b000000, found_addr};
    assign m_tuser = granted;

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for first_fit_bitmap_allocator.
// Models the occupancy map, predicts each result and checks it against the
// result stream. Depends on ffba_pkg and the allocator RTL.
`default_nettype none

module testbench;

    localparam int MAP_UNITS = 1024;

    typedef struct packed {
        logic       granted;
        logic [9:0] found_addr;
    } alloc_result_t;

    typedef struct {
        int unsigned base;
        int unsigned len;
    } region_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    // Shadow copy of the allocator map: 1 = unit used.
    logic [MAP_UNITS-1:0] shadow_map;
    // Results still owed by the block, oldest first.
    alloc_result_t        owed_results[$];
    // Regions handed out and not yet returned, used to build legal frees.
    region_t              live_regions[$];
    int                   gap_pct;
    int                   stall_pct;
    int                   error_count;

    first_fit_bitmap_allocator #(.SLOTS(MAP_UNITS)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // First start unit whose circular run of len units is free; -1 if none.
    function automatic int first_free_run(int unsigned len);
        int unsigned s;
        int unsigned k;
        logic        blocked;
        s = 0;
        while (s < MAP_UNITS) begin
            if (shadow_map[s]) begin
                s++;
            end else begin
                blocked = 1'b0;
                for (k = 0; k < len; k++) begin
                    if (shadow_map[(s + k) % MAP_UNITS]) begin
                        blocked = 1'b1;
                        break;
                    end
                end
                if (!blocked)
                    return s;
                // every start up to the used unit also covers it, skip past it
                s = s + k + 1;
            end
        end
        return -1;
    endfunction

    function automatic void mark_run(int unsigned base, int unsigned len, logic used);
        for (int unsigned k = 0; k < len; k++)
            shadow_map[(base + k) % MAP_UNITS] = used;
    endfunction

    // Apply one accepted transaction to the shadow map; return its result.
    function automatic alloc_result_t apply_request(logic [1:0] kind, logic [9:0] addr,
                                                    logic [10:0] len);
        alloc_result_t res;
        int            hit;
        int unsigned   n;
        res = '0;
        n = len;
        case (kind)
            ffba_pkg::KIND_ALLOC: begin
                if (n >= 1 && n <= MAP_UNITS) begin
                    hit = first_free_run(n);
                    if (hit >= 0) begin
                        mark_run(hit, n, 1'b1);
                        res.granted    = 1'b1;
                        res.found_addr = hit[9:0];
                        live_regions.push_back('{base: hit, len: n});
                    end
                end
            end
            ffba_pkg::KIND_FREE: begin
                if (n > MAP_UNITS)
                    n = MAP_UNITS;
                mark_run(addr % MAP_UNITS, n, 1'b0);
                res.granted = 1'b1;
            end
            ffba_pkg::KIND_CLEAR: begin
                shadow_map = '0;
                live_regions.delete();
                res.granted = 1'b1;
            end
            default: ;   // unused kind: no grant, map untouched
        endcase
        return res;
    endfunction

    // Send one transaction, holding it until accepted, then log its result.
    task automatic send_request(logic [1:0] kind, logic [9:0] addr, logic [10:0] len);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b0, len, addr};
        do @(posedge aclk); while (!s_tready);
        owed_results.push_back(apply_request(kind, addr, len));
    endtask

    // Receiver side: stall at random per the current pressure setting.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare every accepted result with the oldest owed one.
    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result granted=%0b found_addr=%0d",
                         $time, m_tuser, m_tdata[9:0]);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                if (m_tuser !== want.granted) begin
                    $display("%0t: granted mismatch expected %0b actual %0b",
                             $time, want.granted, m_tuser);
                    error_count++;
                end
                if (m_tdata[9:0] !== want.found_addr) begin
                    $display("%0t: found_addr mismatch expected %0d actual %0d",
                             $time, want.found_addr, m_tdata[9:0]);
                    error_count++;
                end
                if (m_tdata[15:10] !== 6'b0) begin
                    $display("%0t: tdata pad mismatch expected 0 actual %0h",
                             $time, m_tdata[15:10]);
                    error_count++;
                end
            end
        end
    end

    // Hold off until every owed result has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge aclk);
    endtask

    // Field extremes, zero and oversized lengths, unused kind, full map.
    task automatic test_extremes();
        send_request(ffba_pkg::KIND_ALLOC, 10'd0, 11'd0);        // zero length: no grant
        send_request(ffba_pkg::KIND_ALLOC, 10'd0, 11'd2047);     // above map size: no grant
        send_request(ffba_pkg::KIND_ALLOC, 10'd0, 11'd1025);
        send_request(ffba_pkg::KIND_ALLOC, 10'd1023, 11'd1024);  // whole map
        send_request(ffba_pkg::KIND_ALLOC, 10'd0, 11'd1);        // map full: no grant
        send_request(ffba_pkg::KIND_FREE, 10'd1023, 11'd0);      // zero-length free
        send_request(ffba_pkg::KIND_FREE, 10'd1023, 11'd2047);   // clamps to the whole map
        send_request(ffba_pkg::KIND_ALLOC, 10'd0, 11'd1);
        send_request(ffba_pkg::KIND_ALLOC, 10'd0, 11'd1023);
        send_request(2'd3, 10'h3FF, 11'h7FF);                    // unused kind
        send_request(ffba_pkg::KIND_CLEAR, 10'h2AA, 11'h555);
    endtask

    // Runs that wrap past the top of the map, for alloc and for free.
    task automatic test_wrap();
        send_request(ffba_pkg::KIND_ALLOC, 10'd0, 11'd1000);
        send_request(ffba_pkg::KIND_FREE, 10'd0, 11'd10);
        send_request(ffba_pkg::KIND_ALLOC, 10'd0, 11'd30);       // fits only across the top
        send_request(ffba_pkg::KIND_FREE, 10'd1020, 11'd8);      // free wraps to unit 3
        send_request(ffba_pkg::KIND_ALLOC, 10'd0, 11'd5);
        send_request(ffba_pkg::KIND_ALLOC, 10'd0, 11'd2);
        send_request(ffba_pkg::KIND_CLEAR, 10'd0, 11'd0);
        send_request(ffba_pkg::KIND_ALLOC, 10'd0, 11'd512);
        send_request(ffba_pkg::KIND_ALLOC, 10'd0, 11'd513);      // one short: no grant
        send_request(ffba_pkg::KIND_CLEAR, 10'd0, 11'd1);
    endtask

    // Mostly alloc/free traffic against live regions, plus noise.
    task automatic test_random(int items);
        int          pick;
        int          idx;
        logic [10:0] len;
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                len = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
                                               : 11'($urandom_range(48, 1));
                send_request(ffba_pkg::KIND_ALLOC, 10'($urandom), len);
            end else if (pick < 85 && live_regions.size() != 0) begin
                idx = $urandom_range(live_regions.size() - 1);
                send_request(ffba_pkg::KIND_FREE, 10'(live_regions[idx].base),
                             11'(live_regions[idx].len));
                live_regions.delete(idx);
            end else if (pick < 92) begin
                send_request(ffba_pkg::KIND_FREE, 10'($urandom), 11'($urandom));
            end else if (pick < 95) begin
                send_request(ffba_pkg::KIND_CLEAR, 10'($urandom), 11'($urandom));
            end else begin
                send_request(2'd3, 10'($urandom), 11'($urandom));
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        gap_pct     = 24;
        stall_pct   = 50;
        error_count = 0;
        shadow_map  = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_extremes();
        test_wrap();
        test_random(160);
        wait_drained();            // sender pauses until everything is back
        gap_pct   = 50;
        stall_pct = 24;
        test_random(160);
        gap_pct   = 0;
        stall_pct = 0;
        test_random(160);
        wait_drained();
        repeat (600) @(posedge aclk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #40_000_000;
        $display("%0t: timeout, %0d results still owed", $time, owed_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

### first_fit_bitmap_allocator.f
rtl/ffba_pkg.sv
rtl/ffba_dpath.sv
rtl/ffba_ctrl.sv
rtl/first_fit_bitmap_allocator.sv
tb/testbench.sv
